/* src/bsm_pkg.sv */
package bsm_pkg;

  // Bank count limits and the power-up configuration.
  localparam int MAX_PRG_BANKS = 64;
  localparam int MAX_CHR_BANKS = 256;
  localparam int MIN_PRG_BANKS = 2;
  localparam int MIN_CHR_BANKS = 8;

  localparam int PRG_COUNT_W = 7;
  localparam int CHR_COUNT_W = 9;
  localparam int PRG_SLOT_W  = $clog2(MAX_PRG_BANKS);
  localparam int CHR_SLOT_W  = 8;

  localparam logic [PRG_COUNT_W-1:0] PRG_COUNT_RESET = 7'd32;
  localparam logic [CHR_COUNT_W-1:0] CHR_COUNT_RESET = 9'd128;

  // Configuration register indexes.
  localparam logic [7:0] CFG_PRG_COUNT = 8'd0;
  localparam logic [7:0] CFG_CHR_COUNT = 8'd1;

  // Commands.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Result targets.
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_CHR  = 2'd1;
  localparam logic [1:0] TGT_SRAM = 2'd2;
  localparam logic [1:0] TGT_PRG  = 2'd3;

  // 8 KB bus regions below 0x8000 and register groups above it.
  localparam logic [2:0] REGION_CHR  = 3'd0;
  localparam logic [2:0] REGION_SRAM = 3'd3;
  localparam logic [1:0] REG_BANK    = 2'd0;
  localparam logic [1:0] REG_MIRROR  = 2'd1;
  localparam logic [1:0] REG_IRQ     = 2'd2;
  localparam logic [1:0] REG_IRQ_EN  = 2'd3;

  // Scanline counter timing.
  localparam logic [8:0] IRQ_DOT           = 9'd280;
  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;
  localparam logic [8:0] PRERENDER_LINE    = 9'd261;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CHR,
    OP_SRAM,
    OP_PRG_READ,
    OP_BANK_SELECT,
    OP_BANK_DATA,
    OP_MIRROR,
    OP_IRQ_RELOAD,
    OP_IRQ_CLEAR,
    OP_IRQ_DISABLE,
    OP_IRQ_ENABLE,
    OP_TICK
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] addr;
    logic [7:0]  value;
    logic        write;
  } item_t;

  typedef struct packed {
    logic                   start;
    logic [7:0]             value;
    logic [CHR_COUNT_W-1:0] modulus;
  } wrap_req_t;

  typedef struct packed {
    logic                   valid;
    logic [7:0]             index;
    logic [CHR_COUNT_W-1:0] data;
  } cfg_wr_t;

  function automatic logic [PRG_COUNT_W-1:0] prg_clamp(input logic [PRG_COUNT_W-1:0] c);
    logic [PRG_COUNT_W-1:0] r;
    r = c;
    if (c < PRG_COUNT_W'(MIN_PRG_BANKS)) r = PRG_COUNT_W'(MIN_PRG_BANKS);
    if (c > PRG_COUNT_W'(MAX_PRG_BANKS)) r = PRG_COUNT_W'(MAX_PRG_BANKS);
    return r;
  endfunction

  function automatic logic [CHR_COUNT_W-1:0] chr_clamp(input logic [CHR_COUNT_W-1:0] c);
    logic [CHR_COUNT_W-1:0] r;
    r = c;
    if (c < CHR_COUNT_W'(MIN_CHR_BANKS)) r = CHR_COUNT_W'(MIN_CHR_BANKS);
    if (c > CHR_COUNT_W'(MAX_CHR_BANKS)) r = CHR_COUNT_W'(MAX_CHR_BANKS);
    return r;
  endfunction

endpackage

/* src/bank_switch_mapper_with_scanline_irq_core.sv */
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i / in_stall_o  command, bus address, write value, PPU state
// output    out        out_valid_o / out_stall_i  target, memory address, write, irq, mirror
// config    in         cfg_valid_i / cfg_ready_o  register index, write data
//
// Reads, writes and ticks are taken one per cycle while the queue has room and are
// answered from a registered output. A bank select or bank data write runs ten slot
// banks one at a time through a shared remainder unit that retires one bit a cycle.
// Reset is asynchronous and leaves the power-up bank layout; there is no clearing pass.
// A two-entry queue keeps taking transactions while the output register is stalled.
module bank_switch_mapper_with_scanline_irq_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] bus_address_i,
  input  logic [7:0]  write_value_i,
  input  logic [8:0]  ppu_dot_i,
  input  logic [8:0]  ppu_scanline_i,
  input  logic        show_background_i,
  input  logic        show_sprites_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  target_o,
  output logic [18:0] mem_address_o,
  output logic        mem_write_o,
  output logic        irq_pulse_o,
  output logic        mirror_horizontal_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);
  import bsm_pkg::*;

  logic      q_full;
  logic      q_push;
  item_t     q_push_item;
  logic      q_pop;
  logic      q_empty;
  item_t     q_head;
  wrap_req_t wrap_req;
  logic      wrap_done;
  logic [7:0] wrap_result;
  cfg_wr_t   cfg_wr;

  // Configuration must only be written while the mapper is idle; the block does not enforce it.
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i && cfg_ready_o;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  bsm_front u_front (
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .bus_address_i     (bus_address_i),
    .write_value_i     (write_value_i),
    .ppu_dot_i         (ppu_dot_i),
    .ppu_scanline_i    (ppu_scanline_i),
    .show_background_i (show_background_i),
    .show_sprites_i    (show_sprites_i),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_item_o          (q_push_item)
  );

  bsm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  bsm_wrap u_wrap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (wrap_req),
    .done_o   (wrap_done),
    .result_o (wrap_result)
  );

  bsm_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_wr),
    .q_empty_i           (q_empty),
    .q_head_i            (q_head),
    .q_pop_o             (q_pop),
    .wrap_req_o          (wrap_req),
    .wrap_done_i         (wrap_done),
    .wrap_result_i       (wrap_result),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .target_o            (target_o),
    .mem_address_o       (mem_address_o),
    .mem_write_o         (mem_write_o),
    .irq_pulse_o         (irq_pulse_o),
    .mirror_horizontal_o (mirror_horizontal_o)
  );

endmodule

/* src/bsm_front.sv */
module bsm_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  input  logic [15:0]       bus_address_i,
  input  logic [7:0]        write_value_i,
  input  logic [8:0]        ppu_dot_i,
  input  logic [8:0]        ppu_scanline_i,
  input  logic              show_background_i,
  input  logic              show_sprites_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output bsm_pkg::item_t    q_item_o
);
  import bsm_pkg::*;

  logic [2:0] region;
  logic       odd;
  logic       counted_line;
  logic       clocks_counter;

  assign region = bus_address_i[15:13];
  assign odd    = bus_address_i[0];

  // Lines 240 through 260 are the vertical blank, where the counter rests.
  assign counted_line   = !(ppu_scanline_i > LAST_VISIBLE_LINE &&
                            ppu_scanline_i < PRERENDER_LINE);
  assign clocks_counter = (ppu_dot_i == IRQ_DOT) && counted_line &&
                          (show_background_i || show_sprites_i);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.op    = OP_NONE;
    q_item_o.addr  = bus_address_i;
    q_item_o.value = write_value_i;
    q_item_o.write = (command_i == CMD_WRITE);
    case (command_i)
      CMD_READ, CMD_WRITE: begin
        if (region == REGION_CHR) begin
          q_item_o.op = OP_CHR;
        end else if (region == REGION_SRAM) begin
          q_item_o.op = OP_SRAM;
        end else if (bus_address_i[15]) begin
          if (command_i == CMD_READ) begin
            q_item_o.op = OP_PRG_READ;
          end else begin
            case (bus_address_i[14:13])
              REG_BANK:   q_item_o.op = odd ? OP_BANK_DATA : OP_BANK_SELECT;
              REG_MIRROR: q_item_o.op = odd ? OP_NONE : OP_MIRROR;
              REG_IRQ:    q_item_o.op = odd ? OP_IRQ_CLEAR : OP_IRQ_RELOAD;
              REG_IRQ_EN: q_item_o.op = odd ? OP_IRQ_ENABLE : OP_IRQ_DISABLE;
              default:    q_item_o.op = OP_NONE;
            endcase
          end
        end
      end
      CMD_TICK: begin
        if (clocks_counter) q_item_o.op = OP_TICK;
      end
      default: q_item_o.op = OP_NONE;
    endcase
  end

endmodule

/* src/bsm_queue.sv */
module bsm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bsm_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output bsm_pkg::item_t head_o
);
  import bsm_pkg::*;

  item_t             entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic [QPTR_W:0]   count_d;

  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wr_ptr_q] <= push_item_i;
  end

endmodule

/* src/bsm_wrap.sv */
module bsm_wrap (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsm_pkg::wrap_req_t req_i,
  output logic               done_o,
  output logic [7:0]         result_o
);
  import bsm_pkg::*;

  // Floor remainder of a signed byte by a bank count, one quotient bit per
  // cycle on the magnitude, with the sign folded in at the end.
  logic                   busy_q;
  logic                   done_q;
  logic [2:0]             step_q;
  logic [7:0]             mag_q;
  logic [7:0]             rem_q;
  logic                   neg_q;
  logic [CHR_COUNT_W-1:0] mod_q;
  logic [8:0]             trial;
  logic [7:0]             rem_d;
  logic [CHR_COUNT_W-1:0] wrapped;

  assign trial = {rem_q, mag_q[7]};

  always_comb begin
    if (trial >= mod_q) begin
      rem_d = 8'(trial - mod_q);
    end else begin
      rem_d = trial[7:0];
    end
  end

  assign wrapped  = mod_q - {1'b0, rem_q};
  assign result_o = (neg_q && rem_q != '0) ? wrapped[7:0] : rem_q;
  assign done_o   = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == 3'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mag_q <= req_i.value[7] ? (~req_i.value + 8'd1) : req_i.value;
      neg_q <= req_i.value[7];
      mod_q <= req_i.modulus;
      rem_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[6:0], 1'b0};
      rem_q <= rem_d;
    end
  end

endmodule

/* src/bsm_back.sv */
module bsm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsm_pkg::cfg_wr_t   cfg_i,
  input  logic               q_empty_i,
  input  bsm_pkg::item_t     q_head_i,
  output logic               q_pop_o,
  output bsm_pkg::wrap_req_t wrap_req_o,
  input  logic               wrap_done_i,
  input  logic [7:0]         wrap_result_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         target_o,
  output logic [18:0]        mem_address_o,
  output logic               mem_write_o,
  output logic               irq_pulse_o,
  output logic               mirror_horizontal_o
);
  import bsm_pkg::*;

  localparam int NUM_WRAP_OPS = 10;
  localparam int OP_IDX_W     = $clog2(NUM_WRAP_OPS);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_START  = 5'b00010,
    ST_WAIT   = 5'b00100,
    ST_COMMIT = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e                 state_q;
  state_e                 state_d;
  logic [PRG_COUNT_W-1:0] prg_count_q;
  logic [CHR_COUNT_W-1:0] chr_count_q;
  logic [PRG_COUNT_W-1:0] prg_eff;
  logic [PRG_COUNT_W-1:0] prg_cfg_eff;
  logic [7:0]             bank_values_q [8];
  logic [2:0]             bank_select_q;
  logic                   prg_swap_q;
  logic                   chr_invert_q;
  logic [PRG_SLOT_W-1:0]  prg_slot_q [4];
  logic [CHR_SLOT_W-1:0]  chr_slot_q [8];
  logic [7:0]             irq_count_q;
  logic [7:0]             irq_reload_q;
  logic                   irq_enabled_q;
  logic                   mirror_q;
  logic [OP_IDX_W-1:0]    op_idx_q;
  logic [7:0]             res_q [NUM_WRAP_OPS];

  logic                   out_free;
  logic                   head_bank;
  logic                   exec;
  logic                   emit_direct;
  logic                   emit_done;
  logic                   cfg_prg_wr;
  logic                   cfg_chr_wr;

  logic [1:0]             res_target;
  logic [18:0]            res_address;
  logic                   res_write;
  logic                   res_pulse;
  logic                   res_mirror;

  logic                   out_valid_q;
  logic [1:0]             target_q;
  logic [18:0]            mem_address_q;
  logic                   mem_write_q;
  logic                   irq_pulse_q;
  logic                   mirror_out_q;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign head_bank   = (q_head_i.op == OP_BANK_SELECT) || (q_head_i.op == OP_BANK_DATA);
  assign q_pop_o     = (state_q == ST_IDLE) && !q_empty_i && (head_bank || out_free);
  assign exec        = q_pop_o;
  assign emit_direct = exec && !head_bank;
  assign emit_done   = (state_q == ST_DONE) && out_free;
  assign cfg_prg_wr  = cfg_i.valid && (cfg_i.index == CFG_PRG_COUNT);
  assign cfg_chr_wr  = cfg_i.valid && (cfg_i.index == CFG_CHR_COUNT);
  assign prg_eff     = prg_clamp(prg_count_q);
  assign prg_cfg_eff = prg_clamp(cfg_i.data[PRG_COUNT_W-1:0]);

  // Sequencer: a bank register write runs every slot bank through the
  // shared remainder unit before its transaction is answered.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (exec && head_bank) state_d = ST_START;
      ST_START:  state_d = ST_WAIT;
      ST_WAIT: begin
        if (wrap_done_i) begin
          state_d = (op_idx_q == OP_IDX_W'(NUM_WRAP_OPS - 1)) ? ST_COMMIT : ST_START;
        end
      end
      ST_COMMIT: state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Operands 0 and 1 are the two switchable program banks, 2 to 5 the
  // halves of the 2 KB character pairs, 6 to 9 the 1 KB character banks.
  always_comb begin
    wrap_req_o.start   = (state_q == ST_START);
    wrap_req_o.value   = '0;
    wrap_req_o.modulus = chr_clamp(chr_count_q);
    case (op_idx_q)
      4'd0: begin
        wrap_req_o.value   = bank_values_q[6];
        wrap_req_o.modulus = CHR_COUNT_W'(prg_eff);
      end
      4'd1: begin
        wrap_req_o.value   = bank_values_q[7];
        wrap_req_o.modulus = CHR_COUNT_W'(prg_eff);
      end
      4'd2:    wrap_req_o.value = bank_values_q[0] & 8'hfe;
      4'd3:    wrap_req_o.value = bank_values_q[0] | 8'h01;
      4'd4:    wrap_req_o.value = bank_values_q[1] & 8'hfe;
      4'd5:    wrap_req_o.value = bank_values_q[1] | 8'h01;
      4'd6:    wrap_req_o.value = bank_values_q[2];
      4'd7:    wrap_req_o.value = bank_values_q[3];
      4'd8:    wrap_req_o.value = bank_values_q[4];
      4'd9:    wrap_req_o.value = bank_values_q[5];
      default: wrap_req_o.value = '0;
    endcase
  end

  always_comb begin
    res_target  = TGT_NONE;
    res_address = '0;
    res_write   = 1'b0;
    res_pulse   = 1'b0;
    res_mirror  = mirror_q;
    case (q_head_i.op)
      OP_CHR: begin
        res_target  = TGT_CHR;
        res_address = 19'({chr_slot_q[q_head_i.addr[12:10]], q_head_i.addr[9:0]});
        res_write   = q_head_i.write;
      end
      OP_SRAM: begin
        res_target  = TGT_SRAM;
        res_address = 19'(q_head_i.addr[12:0]);
        res_write   = q_head_i.write;
      end
      OP_PRG_READ: begin
        res_target  = TGT_PRG;
        res_address = {prg_slot_q[q_head_i.addr[14:13]], q_head_i.addr[12:0]};
      end
      OP_MIRROR: res_mirror = q_head_i.value[0];
      OP_TICK:   res_pulse  = (irq_count_q == 8'd1) && irq_enabled_q;
      default:   res_target = TGT_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (exec && head_bank) begin
        op_idx_q <= '0;
      end else if (state_q == ST_WAIT && wrap_done_i) begin
        op_idx_q <= op_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WAIT && wrap_done_i) res_q[op_idx_q] <= wrap_result_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q <= PRG_COUNT_RESET;
      chr_count_q <= CHR_COUNT_RESET;
    end else begin
      if (cfg_prg_wr) prg_count_q <= cfg_i.data[PRG_COUNT_W-1:0];
      if (cfg_chr_wr) chr_count_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) bank_values_q[i] <= '0;
      bank_select_q <= '0;
      prg_swap_q    <= 1'b0;
      chr_invert_q  <= 1'b0;
      irq_count_q   <= '0;
      irq_reload_q  <= '0;
      irq_enabled_q <= 1'b0;
      mirror_q      <= 1'b0;
    end else if (exec) begin
      case (q_head_i.op)
        OP_BANK_SELECT: begin
          bank_select_q <= q_head_i.value[2:0];
          prg_swap_q    <= q_head_i.value[6];
          chr_invert_q  <= q_head_i.value[7];
        end
        OP_BANK_DATA:   bank_values_q[bank_select_q] <= q_head_i.value;
        OP_MIRROR:      mirror_q <= q_head_i.value[0];
        OP_IRQ_RELOAD:  irq_reload_q <= q_head_i.value;
        OP_IRQ_CLEAR:   irq_count_q <= '0;
        OP_IRQ_DISABLE: irq_enabled_q <= 1'b0;
        OP_IRQ_ENABLE:  irq_enabled_q <= 1'b1;
        OP_TICK: begin
          if (irq_count_q == '0) begin
            irq_count_q <= irq_reload_q;
          end else begin
            irq_count_q <= irq_count_q - 8'd1;
          end
        end
        default: irq_count_q <= irq_count_q;
      endcase
    end
  end

  // A program count write sets the program slots at once to banks 0 and 1 and the last two banks of the new count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_slot_q[0] <= '0;
      prg_slot_q[1] <= PRG_SLOT_W'(1);
      prg_slot_q[2] <= PRG_SLOT_W'(PRG_COUNT_RESET - 7'd2);
      prg_slot_q[3] <= PRG_SLOT_W'(PRG_COUNT_RESET - 7'd1);
      for (int i = 0; i < 8; i++) chr_slot_q[i] <= '0;
    end else if (cfg_prg_wr) begin
      prg_slot_q[0] <= '0;
      prg_slot_q[1] <= PRG_SLOT_W'(1);
      prg_slot_q[2] <= PRG_SLOT_W'(prg_cfg_eff - 7'd2);
      prg_slot_q[3] <= PRG_SLOT_W'(prg_cfg_eff - 7'd1);
    end else if (state_q == ST_COMMIT) begin
      prg_slot_q[0] <= prg_swap_q ? PRG_SLOT_W'(prg_eff - 7'd2) : res_q[0][PRG_SLOT_W-1:0];
      prg_slot_q[1] <= res_q[1][PRG_SLOT_W-1:0];
      prg_slot_q[2] <= prg_swap_q ? res_q[0][PRG_SLOT_W-1:0] : PRG_SLOT_W'(prg_eff - 7'd2);
      prg_slot_q[3] <= PRG_SLOT_W'(prg_eff - 7'd1);
      for (int i = 0; i < 4; i++) begin
        chr_slot_q[i]     <= chr_invert_q ? res_q[6 + i] : res_q[2 + i];
        chr_slot_q[4 + i] <= chr_invert_q ? res_q[2 + i] : res_q[6 + i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_direct || emit_done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_direct) begin
      target_q      <= res_target;
      mem_address_q <= res_address;
      mem_write_q   <= res_write;
      irq_pulse_q   <= res_pulse;
      mirror_out_q  <= res_mirror;
    end else if (emit_done) begin
      target_q      <= TGT_NONE;
      mem_address_q <= '0;
      mem_write_q   <= 1'b0;
      irq_pulse_q   <= 1'b0;
      mirror_out_q  <= mirror_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign target_o            = target_q;
  assign mem_address_o       = mem_address_q;
  assign mem_write_o         = mem_write_q;
  assign irq_pulse_o         = irq_pulse_q;
  assign mirror_horizontal_o = mirror_out_q;

endmodule

/* dv/bank_switch_mapper_with_scanline_irq_core_tb.sv */
`timescale 1ns / 100ps

module bank_switch_mapper_with_scanline_irq_core_tb;
  import bsm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [7:0] CFG_UNUSED = 8'd2;
  localparam int IDLE_PCT      = 21;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_AT       = 600;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PRINT_CAP     = 100;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [8:0]  dot;
    logic [8:0]  line;
    logic        bg;
    logic        spr;
  } bus_txn_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [18:0] mem_addr;
    logic        mem_wr;
    logic        irq;
    logic        mirror_h;
  } map_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  bus_txn_t   cur_txn     = '0;
  logic       out_stall_i = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic [7:0] cfg_index_i = '0;
  logic [8:0] cfg_data_i  = '0;

  wire        in_stall_o;
  wire        out_valid_o;
  wire [1:0]  target_o;
  wire [18:0] mem_address_o;
  wire        mem_write_o;
  wire        irq_pulse_o;
  wire        mirror_horizontal_o;
  wire        cfg_ready_o;

  bus_txn_t    pending_q[$];
  map_result_t mapped_q[$];
  int queued_n    = 0;
  int accepted_n  = 0;
  int results_n   = 0;
  int mismatches  = 0;
  int cycle_n     = 0;
  int hold_left   = 0;
  bit steady      = 1'b0;

  // Mapper state as the testbench tracks it.
  logic [6:0] m_prg_banks;
  logic [8:0] m_chr_banks;
  logic [7:0] m_bank_reg [8];
  logic [2:0] m_select;
  logic       m_prg_swap;
  logic       m_chr_flip;
  logic [5:0] m_prg_map [4];
  logic [7:0] m_chr_map [8];
  logic [7:0] m_scan_count;
  logic [7:0] m_scan_latch;
  logic       m_irq_armed;
  logic       m_mirror_h;

  bank_switch_mapper_with_scanline_irq_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .command_i           (cur_txn.cmd),
    .bus_address_i       (cur_txn.addr),
    .write_value_i       (cur_txn.data),
    .ppu_dot_i           (cur_txn.dot),
    .ppu_scanline_i      (cur_txn.line),
    .show_background_i   (cur_txn.bg),
    .show_sprites_i      (cur_txn.spr),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .target_o            (target_o),
    .mem_address_o       (mem_address_o),
    .mem_write_o         (mem_write_o),
    .irq_pulse_o         (irq_pulse_o),
    .mirror_horizontal_o (mirror_horizontal_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // The count is clamped to its legal range before the signed index is folded into it.
  function automatic int wrap_bank(input int idx, input int count, input int lo, input int hi);
    int n;
    int r;
    n = (count < lo) ? lo : ((count > hi) ? hi : count);
    r = idx % n;
    return (r < 0) ? r + n : r;
  endfunction

  function automatic logic [5:0] prg_bank(input int idx);
    return 6'(wrap_bank(idx, int'(m_prg_banks), MIN_PRG_BANKS, MAX_PRG_BANKS));
  endfunction

  function automatic logic [7:0] chr_bank(input logic [7:0] v);
    return 8'(wrap_bank(int'($signed(v)), int'(m_chr_banks), MIN_CHR_BANKS, MAX_CHR_BANKS));
  endfunction

  function automatic void load_fixed_prg();
    m_prg_map[0] = prg_bank(0);
    m_prg_map[1] = prg_bank(1);
    m_prg_map[2] = prg_bank(-2);
    m_prg_map[3] = prg_bank(-1);
  endfunction

  function automatic void remap_banks();
    logic [7:0] lo [4];
    logic [7:0] hi [4];
    logic [5:0] r6;
    r6 = prg_bank(int'($signed(m_bank_reg[6])));
    m_prg_map[0] = m_prg_swap ? prg_bank(-2) : r6;
    m_prg_map[1] = prg_bank(int'($signed(m_bank_reg[7])));
    m_prg_map[2] = m_prg_swap ? r6 : prg_bank(-2);
    m_prg_map[3] = prg_bank(-1);
    // The two 2 KB registers cover an even and an odd 1 KB bank each.
    lo[0] = chr_bank(m_bank_reg[0] & 8'hFE);
    lo[1] = chr_bank(m_bank_reg[0] | 8'h01);
    lo[2] = chr_bank(m_bank_reg[1] & 8'hFE);
    lo[3] = chr_bank(m_bank_reg[1] | 8'h01);
    for (int i = 0; i < 4; i++) begin
      hi[i] = chr_bank(m_bank_reg[2 + i]);
      m_chr_map[i]     = m_chr_flip ? hi[i] : lo[i];
      m_chr_map[4 + i] = m_chr_flip ? lo[i] : hi[i];
    end
  endfunction

  function automatic map_result_t map_transaction(input bus_txn_t t);
    map_result_t r;
    logic odd;
    r = '0;
    odd = t.addr[0];
    if (t.cmd == CMD_READ || t.cmd == CMD_WRITE) begin
      if (t.addr[15:13] == REGION_CHR) begin
        r.target   = TGT_CHR;
        r.mem_addr = 19'({m_chr_map[t.addr[12:10]], t.addr[9:0]});
        r.mem_wr   = (t.cmd == CMD_WRITE);
      end else if (t.addr[15:13] == REGION_SRAM) begin
        r.target   = TGT_SRAM;
        r.mem_addr = 19'(t.addr[12:0]);
        r.mem_wr   = (t.cmd == CMD_WRITE);
      end else if (t.addr[15] && t.cmd == CMD_READ) begin
        r.target   = TGT_PRG;
        r.mem_addr = {m_prg_map[t.addr[14:13]], t.addr[12:0]};
      end else if (t.addr[15]) begin
        case (t.addr[14:13])
          REG_BANK: begin
            if (odd) begin
              m_bank_reg[m_select] = t.data;
            end else begin
              m_select   = t.data[2:0];
              m_prg_swap = t.data[6];
              m_chr_flip = t.data[7];
            end
            remap_banks();
          end
          REG_MIRROR: begin
            if (!odd) m_mirror_h = t.data[0];
          end
          REG_IRQ: begin
            if (odd) m_scan_count = '0;
            else m_scan_latch = t.data;
          end
          REG_IRQ_EN: begin
            m_irq_armed = odd;
          end
          default: ;
        endcase
      end
    end else if (t.cmd == CMD_TICK) begin
      if (t.dot == IRQ_DOT && (t.bg || t.spr) &&
          !(t.line > LAST_VISIBLE_LINE && t.line < PRERENDER_LINE)) begin
        if (m_scan_count == 0) begin
          m_scan_count = m_scan_latch;
        end else begin
          m_scan_count = m_scan_count - 8'd1;
          r.irq = (m_scan_count == 0) && m_irq_armed;
        end
      end
    end
    r.mirror_h = m_mirror_h;
    return r;
  endfunction

  function automatic bus_txn_t bus(input logic [1:0] c, input logic [15:0] a,
                                   input logic [7:0] d);
    bus_txn_t t;
    t = '0;
    t.cmd  = c;
    t.addr = a;
    t.data = d;
    return t;
  endfunction

  function automatic bus_txn_t tick(input logic [8:0] dot, input logic [8:0] line,
                                    input logic bg, input logic spr);
    bus_txn_t t;
    t = '0;
    t.cmd  = CMD_TICK;
    t.dot  = dot;
    t.line = line;
    t.bg   = bg;
    t.spr  = spr;
    return t;
  endfunction

  task automatic offer(input bus_txn_t t);
    pending_q.push_back(t);
    queued_n++;
  endtask

  task automatic flag_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Wait until every transaction, bank remaps included, has been answered, then let the bench idle.
  task automatic settle();
    while (accepted_n != queued_n || mapped_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [7:0] idx, input logic [8:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_PRG_COUNT) begin
      m_prg_banks = data[6:0];
      load_fixed_prg();
    end else if (idx == CFG_CHR_COUNT) begin
      m_chr_banks = data;
    end
  endtask

  task automatic queue_traffic(input int n);
    int pick;
    bus_txn_t t;
    repeat (n) begin
      pick   = $urandom_range(99);
      t.cmd  = CMD_READ;
      t.addr = 16'($urandom);
      t.data = 8'($urandom);
      t.dot  = 9'($urandom);
      t.line = 9'($urandom);
      t.bg   = 1'($urandom);
      t.spr  = 1'($urandom);
      if (pick < 20) begin
        t.addr[15:13] = REGION_CHR;
      end else if (pick < 32) begin
        t.addr[15] = 1'b1;
      end else if (pick < 38) begin
        t.addr[15:13] = REGION_SRAM;
        t.cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
      end else if (pick < 44) begin
        t.addr[15:13] = REGION_CHR;
        t.cmd = CMD_WRITE;
      end else if (pick < 46) begin
        t.addr[15:13] = 3'($urandom_range(1, 2));
        t.cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
      end else if (pick < 56) begin
        // Bank select followed by its bank data, the way software switches a bank.
        t.cmd = CMD_WRITE;
        t.addr[15] = 1'b1;
        t.addr[14:13] = REG_BANK;
        t.addr[0] = 1'b0;
        offer(t);
        t.addr = 16'($urandom);
        t.addr[15] = 1'b1;
        t.addr[14:13] = REG_BANK;
        t.addr[0] = 1'b1;
        t.data = 8'($urandom);
      end else if (pick < 66) begin
        t.cmd = CMD_WRITE;
        t.addr[15] = 1'b1;
        // Short reload values let the counter reach zero often.
        if (t.addr[14:13] == REG_IRQ && $urandom_range(3) != 0) t.data = 8'($urandom_range(6));
      end else if (pick < 97) begin
        t.cmd = CMD_TICK;
        if ($urandom_range(3) != 0) t.dot = IRQ_DOT;
        if ($urandom_range(7) != 0) t.line = 9'($urandom_range(261));
      end else begin
        t.cmd = CMD_UNUSED;
      end
      offer(t);
    end
  endtask

  // Driver: presents queued transactions and keeps a stalled one unchanged.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        mapped_q.push_back(map_transaction(cur_txn));
        accepted_n++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid_i <= 1'b1;
          cur_txn    <= pending_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest mapped transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    map_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_n++;
        if (mapped_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with no transaction waiting", results_n));
        end else begin
          want = mapped_q.pop_front();
          if (target_o !== want.target)
            flag_mismatch($sformatf("result %0d target %0d, expected %0d",
                                    results_n, target_o, want.target));
          if (mem_address_o !== want.mem_addr)
            flag_mismatch($sformatf("result %0d mem_address 0x%05h, expected 0x%05h",
                                    results_n, mem_address_o, want.mem_addr));
          if (mem_write_o !== want.mem_wr)
            flag_mismatch($sformatf("result %0d mem_write %b, expected %b",
                                    results_n, mem_write_o, want.mem_wr));
          if (irq_pulse_o !== want.irq)
            flag_mismatch($sformatf("result %0d irq_pulse %b, expected %b",
                                    results_n, irq_pulse_o, want.irq));
          if (mirror_horizontal_o !== want.mirror_h)
            flag_mismatch($sformatf("result %0d mirror_horizontal %b, expected %b",
                                    results_n, mirror_horizontal_o, want.mirror_h));
        end
        // One long hold-off so the internal queue fills and the input stalls.
        if (results_n == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("bank_switch_mapper_with_scanline_irq_core regression: fail");
      $finish;
    end
  end

  initial begin
    m_prg_banks  = PRG_COUNT_RESET;
    m_chr_banks  = CHR_COUNT_RESET;
    m_select     = '0;
    m_prg_swap   = 1'b0;
    m_chr_flip   = 1'b0;
    m_scan_count = '0;
    m_scan_latch = '0;
    m_irq_armed  = 1'b0;
    m_mirror_h   = 1'b0;
    for (int i = 0; i < 8; i++) begin
      m_bank_reg[i] = '0;
      m_chr_map[i]  = '0;
    end
    load_fixed_prg();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Region edges, unmapped accesses and character writes.
    offer(bus(CMD_READ, 16'h0000, 8'h00));
    offer(bus(CMD_READ, 16'h1FFF, 8'hFF));
    offer(bus(CMD_WRITE, 16'h03FF, 8'hA5));
    offer(bus(CMD_READ, 16'h2000, 8'h00));
    offer(bus(CMD_WRITE, 16'h5FFF, 8'h11));
    offer(bus(CMD_READ, 16'h6000, 8'h00));
    offer(bus(CMD_WRITE, 16'h7FFF, 8'h5A));
    offer(bus(CMD_READ, 16'h8000, 8'h00));
    offer(bus(CMD_READ, 16'hFFFF, 8'h00));
    // Swap and invert modes, then negative bank numbers.
    offer(bus(CMD_WRITE, 16'h8000, 8'hC6));
    offer(bus(CMD_WRITE, 16'h8001, 8'h80));
    offer(bus(CMD_WRITE, 16'h9FFE, 8'h81));
    offer(bus(CMD_WRITE, 16'h9FFF, 8'hFF));
    offer(bus(CMD_READ, 16'h8123, 8'h00));
    offer(bus(CMD_READ, 16'hC456, 8'h00));
    offer(bus(CMD_READ, 16'h1C00, 8'h00));
    offer(bus(CMD_WRITE, 16'hA000, 8'hFF));
    offer(bus(CMD_WRITE, 16'hBFFF, 8'h00));
    // Reload of two, enable, then ticks that load, skip and count down to a pulse.
    offer(bus(CMD_WRITE, 16'hC000, 8'h02));
    offer(bus(CMD_WRITE, 16'hE001, 8'h00));
    offer(tick(IRQ_DOT, 9'd0, 1'b1, 1'b0));
    offer(tick(IRQ_DOT, PRERENDER_LINE, 1'b0, 1'b1));
    offer(tick(IRQ_DOT, 9'd240, 1'b1, 1'b1));
    offer(tick(9'd279, 9'd10, 1'b1, 1'b1));
    offer(tick(IRQ_DOT, 9'd20, 1'b0, 1'b0));
    offer(tick(IRQ_DOT, 9'd511, 1'b1, 1'b1));
    offer(bus(CMD_WRITE, 16'hC001, 8'h00));
    offer(bus(CMD_UNUSED, 16'hFFFF, 8'hFF));
    settle();

    queue_traffic(250);
    settle();

    write_cfg(CFG_PRG_COUNT, 9'd2);
    write_cfg(CFG_CHR_COUNT, 9'd8);
    queue_traffic(200);
    settle();

    // No gaps on either side for this whole stretch.
    steady = 1'b1;
    write_cfg(CFG_PRG_COUNT, 9'd64);
    write_cfg(CFG_CHR_COUNT, 9'd256);
    queue_traffic(200);
    settle();
    steady = 1'b0;

    // Counts below the minimum are clamped up.
    write_cfg(CFG_PRG_COUNT, 9'd0);
    write_cfg(CFG_CHR_COUNT, 9'd0);
    queue_traffic(150);
    settle();

    // Counts above the maximum are clamped down; an unknown index changes nothing.
    write_cfg(CFG_PRG_COUNT, 9'h1FF);
    write_cfg(CFG_CHR_COUNT, 9'h1FF);
    write_cfg(CFG_UNUSED, 9'd5);
    queue_traffic(150);
    settle();

    for (int k = 0; k < 4; k++) begin
      write_cfg(CFG_PRG_COUNT,
                ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(2, 64)));
      write_cfg(CFG_CHR_COUNT,
                ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(8, 256)));
      queue_traffic(150);
      settle();
    end

    if (mismatches == 0) begin
      $display("bank_switch_mapper_with_scanline_irq_core regression: pass");
    end else begin
      $display("bank_switch_mapper_with_scanline_irq_core regression: fail");
    end
    $finish;
  end

endmodule
